[src/addressed_frame_receiver_top_macros.svh]
// assertion macros shared by the frame receiver checker
`ifndef ADDRESSED_FRAME_RECEIVER_TOP_MACROS_SVH
`define ADDRESSED_FRAME_RECEIVER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define AFR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define AFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/afr_pkg.sv]
// shared types and constants of the addressed frame receiver
package afr_pkg;

	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BCAST_ADDR = 1'b1;

	localparam logic [7:0] OWN_ADDR_RESET   = 8'h0C;
	localparam logic [7:0] BCAST_ADDR_RESET = 8'h3F;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic [4:0] position;
		logic       is_broadcast;
		logic       last_byte;
		logic       length_error;
	} afr_result_t;

endpackage

[src/afr_parse.sv]
// frame state tracking and per-byte decode
module afr_parse #(
	parameter int MAX_DATA = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          own_addr,
	input  logic [7:0]          bcast_addr,
	output logic                produce,
	output afr_pkg::afr_result_t res
);
	import afr_pkg::*;

	localparam int CNT_W = $clog2(MAX_DATA + 4);
	localparam int LEN_W = $clog2(MAX_DATA + 1);

	logic             in_frame_q;
	logic [CNT_W-1:0] byte_count_q;
	logic [LEN_W-1:0] data_length_q;
	logic             bcast_seen_q;

	logic             hit_own;
	logic             hit_bcast;
	logic             too_long;
	logic             at_len;
	logic             at_end;

	assign hit_own   = (rx_byte == own_addr);
	assign hit_bcast = (rx_byte == bcast_addr);
	assign too_long  = (rx_byte > 8'(MAX_DATA));
	assign at_len    = (byte_count_q == CNT_W'(1));
	// final position is three past the length byte value
	assign at_end    = (byte_count_q == CNT_W'(3) + CNT_W'(data_length_q));

	always_comb begin
		res.frame_byte   = rx_byte;
		res.position     = 5'(byte_count_q);
		res.is_broadcast = bcast_seen_q;
		res.last_byte    = 1'b0;
		res.length_error = 1'b0;
		produce          = 1'b1;
		if (!in_frame_q) begin
			produce          = hit_own | hit_bcast;
			res.position     = '0;
			res.is_broadcast = hit_bcast;
		end else if (at_len) begin
			res.last_byte    = too_long;
			res.length_error = too_long;
		end else begin
			res.last_byte    = at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			byte_count_q  <= '0;
			data_length_q <= '0;
			bcast_seen_q  <= 1'b0;
		end else if (take) begin
			if (!in_frame_q) begin
				if (hit_own | hit_bcast) begin
					in_frame_q   <= 1'b1;
					bcast_seen_q <= hit_bcast;
					byte_count_q <= CNT_W'(1);
				end
			end else if (at_len) begin
				if (too_long) begin
					in_frame_q   <= 1'b0;
					byte_count_q <= '0;
				end else begin
					data_length_q <= LEN_W'(rx_byte);
					byte_count_q  <= CNT_W'(2);
				end
			end else if (at_end) begin
				in_frame_q   <= 1'b0;
				byte_count_q <= '0;
			end else begin
				byte_count_q <= byte_count_q + CNT_W'(1);
			end
		end
	end

endmodule

[src/afr_out_buf.sv]
// result register with one skid entry
module afr_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  afr_pkg::afr_result_t push_data,
	output logic                space,
	output logic                out_valid,
	input  logic                out_ready,
	output afr_pkg::afr_result_t out_data
);
	import afr_pkg::*;

	logic        main_v_q;
	logic        skid_v_q;
	afr_result_t main_q;
	afr_result_t skid_q;
	logic        pop;

	assign space     = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;
	assign pop       = main_v_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (!main_v_q) begin
			main_v_q <= push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (pop) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (!main_v_q) begin
			main_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

[src/addressed_frame_receiver_top.sv]
// addressed frame receiver: the result of an input transfer is registered before it shows on out_valid
// throughput one byte per cycle while in_ready is high; the frame decode is one compare and count step
// a result register plus one skid entry let input continue one byte past a stall
// reset clears the frame state, drops pending results and loads the addresses
// 0x0C (own) and 0x3F (broadcast)
module addressed_frame_receiver_top #(
	parameter int MAX_DATA = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    frame_byte,
	output logic [4:0]                    position,
	output logic                          is_broadcast,
	output logic                          last_byte,
	output logic                          length_error,
	input  logic                          wr_en,
	input  logic [afr_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [7:0]                    wr_data
);
	import afr_pkg::*;

	logic [7:0]  own_addr_q;
	logic [7:0]  bcast_addr_q;
	logic        take;
	logic        produce;
	afr_result_t res;
	afr_result_t out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q   <= OWN_ADDR_RESET;
			bcast_addr_q <= BCAST_ADDR_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_OWN_ADDR:   own_addr_q   <= wr_data;
				REG_BCAST_ADDR: bcast_addr_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign take = in_valid && in_ready;

	afr_parse #(
		.MAX_DATA(MAX_DATA)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.rx_byte   (rx_byte),
		.own_addr  (own_addr_q),
		.bcast_addr(bcast_addr_q),
		.produce   (produce),
		.res       (res)
	);

	afr_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take && produce),
		.push_data(res),
		.space    (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_res)
	);

	assign frame_byte   = out_res.frame_byte;
	assign position     = out_res.position;
	assign is_broadcast = out_res.is_broadcast;
	assign last_byte    = out_res.last_byte;
	assign length_error = out_res.length_error;

endmodule

[src/afr_checker.sv]
// port-level checks of the frame receiver and their bind
`include "addressed_frame_receiver_top_macros.svh"

module afr_checker #(
	parameter int MAX_DATA = 16
) (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] frame_byte,
	input logic [4:0] position,
	input logic       is_broadcast,
	input logic       last_byte,
	input logic       length_error
);

	// a stalled result holds
	`AFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(frame_byte) && $stable(position) && $stable(is_broadcast)
		&& $stable(last_byte) && $stable(length_error), "stalled result changed")

	// an aborted frame ends on the length byte
	`AFR_ASSERT_NOW(a_err_on_len, out_valid && length_error,
		last_byte && (position == 5'd1), "length error off the length byte")

	// an abort only for a length above the limit
	`AFR_ASSERT_NOW(a_err_value, out_valid && length_error,
		frame_byte > 8'(MAX_DATA), "length error on a legal length")

endmodule

bind addressed_frame_receiver_top afr_checker #(.MAX_DATA(MAX_DATA)) u_afr_checker (.*);
